[hw/rtl/rmq_pkg.sv]
// shared types, constants and width helpers for the rotation matrix to quaternion unit
package rmq_pkg;

    localparam int DATA_W    = 16;
    localparam int TOL_W     = 10;
    localparam int TOL_SQ_W  = 2 * TOL_W;
    localparam int TOL_RESET = 1;
    localparam int SAT_MAX   = 32767;
    localparam int SAT_MIN   = -32768;
    localparam int LANES     = 4;
    localparam int LANE_X    = 0;
    localparam int LANE_Y    = 1;
    localparam int LANE_Z    = 2;
    localparam int LANE_W    = 3;
    localparam int OUT_W     = LANES * DATA_W + 1;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        BR_W,
        BR_X,
        BR_Y,
        BR_Z
    } t_branch;

    // signed width of the radicand and of every scaled component
    function automatic int calc_aw(input int frac_bits);
        calc_aw = ((frac_bits > 17) ? frac_bits : 17) + 2;
    endfunction

    // width of one queued item: four components, radicand and its bad flag
    function automatic int calc_iw(input int frac_bits);
        calc_iw = 5 * calc_aw(frac_bits) + 1;
    endfunction

endpackage

[hw/rtl/rotation_matrix_to_quaternion_unit.sv]
// path from push to result: front register, middle queue, squares, sum, one root bit per
// stage, numerator, one quotient bit per stage, output register and result queue
// throughput: one transaction per cycle in and out, full pipeline stall on back-pressure
// reset (synchronous, active low) empties every queue and stage and sets the
// zero tolerance to 1; configuration is taken whenever i_cfg_valid is high, ready is always high
module rotation_matrix_to_quaternion_unit #(
    parameter int FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [rmq_pkg::DATA_W-1:0] i_m00,
    input  logic signed [rmq_pkg::DATA_W-1:0] i_m01,
    input  logic signed [rmq_pkg::DATA_W-1:0] i_m02,
    input  logic signed [rmq_pkg::DATA_W-1:0] i_m10,
    input  logic signed [rmq_pkg::DATA_W-1:0] i_m11,
    input  logic signed [rmq_pkg::DATA_W-1:0] i_m12,
    input  logic signed [rmq_pkg::DATA_W-1:0] i_m20,
    input  logic signed [rmq_pkg::DATA_W-1:0] i_m21,
    input  logic signed [rmq_pkg::DATA_W-1:0] i_m22,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [rmq_pkg::DATA_W-1:0] o_quat_x,
    output logic signed [rmq_pkg::DATA_W-1:0] o_quat_y,
    output logic signed [rmq_pkg::DATA_W-1:0] o_quat_z,
    output logic signed [rmq_pkg::DATA_W-1:0] o_quat_w,
    output logic                              o_was_degenerate,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rmq_pkg::TOL_W-1:0]         i_cfg_zero_tolerance
);

    localparam int IW = rmq_pkg::calc_iw(FRAC_BITS);
    localparam int DW = rmq_pkg::DATA_W;

    logic [rmq_pkg::TOL_SQ_W-1:0] r_tol_sq;
    logic                         w_f_valid;
    logic [IW-1:0]                w_f_data;
    logic                         w_mid_full;
    logic                         w_mid_empty;
    logic [IW-1:0]                w_mid_data;
    logic                         w_mid_pop;
    logic                         w_b_push;
    logic [rmq_pkg::OUT_W-1:0]    w_b_data;
    logic                         w_out_full;
    logic [rmq_pkg::OUT_W-1:0]    w_out_data;

    assign o_cfg_ready = 1'b1;

    // only the square of the tolerance is used downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol_sq <= rmq_pkg::TOL_SQ_W'(rmq_pkg::TOL_RESET * rmq_pkg::TOL_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tol_sq <= i_cfg_zero_tolerance * i_cfg_zero_tolerance;
        end
    end

    rmq_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_m00   (i_m00),
        .i_m01   (i_m01),
        .i_m02   (i_m02),
        .i_m10   (i_m10),
        .i_m11   (i_m11),
        .i_m12   (i_m12),
        .i_m20   (i_m20),
        .i_m21   (i_m21),
        .i_m22   (i_m22),
        .o_valid (w_f_valid),
        .o_data  (w_f_data),
        .i_ready (!w_mid_full)
    );

    rmq_fifo #(
        .WIDTH (IW)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  (w_f_data),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_data),
        .o_empty (w_mid_empty)
    );

    rmq_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_mid_empty),
        .i_data   (w_mid_data),
        .o_pop    (w_mid_pop),
        .i_tol_sq (r_tol_sq),
        .o_push   (w_b_push),
        .o_data   (w_b_data),
        .i_full   (w_out_full)
    );

    rmq_fifo #(
        .WIDTH (rmq_pkg::OUT_W)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_b_push),
        .i_data  (w_b_data),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out_data),
        .o_empty (empty)
    );

    assign o_quat_x         = $signed(w_out_data[DW*rmq_pkg::LANE_X +: DW]);
    assign o_quat_y         = $signed(w_out_data[DW*rmq_pkg::LANE_Y +: DW]);
    assign o_quat_z         = $signed(w_out_data[DW*rmq_pkg::LANE_Z +: DW]);
    assign o_quat_w         = $signed(w_out_data[DW*rmq_pkg::LANE_W +: DW]);
    assign o_was_degenerate = w_out_data[DW*rmq_pkg::LANES];

endmodule

[hw/rtl/rmq_fifo.sv]
// two-entry queue used between the front, the back and the result side
module rmq_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = rmq_pkg::Q_PTR_W;
    localparam int CW = rmq_pkg::Q_PTR_W + 1;

    logic [WIDTH-1:0] r_mem [rmq_pkg::Q_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CW'(rmq_pkg::Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hw/rtl/rmq_front.sv]
// front end: takes a matrix, picks the branch and forms the scaled quaternion
module rmq_front #(
    parameter int FRAC_BITS = 14
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m00,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m01,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m02,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m10,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m11,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m12,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m20,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m21,
    input  logic signed [rmq_pkg::DATA_W-1:0]  i_m22,
    output logic                               o_valid,
    output logic [rmq_pkg::calc_iw(FRAC_BITS)-1:0] o_data,
    input  logic                               i_ready
);

    localparam int AW = rmq_pkg::calc_aw(FRAC_BITS);
    localparam int IW = rmq_pkg::calc_iw(FRAC_BITS);
    localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;

    logic signed [AW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [AW-1:0] w_trace;
    logic signed [AW-1:0] w_a;
    logic signed [AW-1:0] w_p [rmq_pkg::LANES];
    logic                 w_bad;
    rmq_pkg::t_branch     w_branch;
    logic [IW-1:0]        n_data;
    logic                 r_valid;
    logic [IW-1:0]        r_data;
    logic                 w_advance;

    always_comb begin
        e00 = AW'(i_m00);
        e01 = AW'(i_m01);
        e02 = AW'(i_m02);
        e10 = AW'(i_m10);
        e11 = AW'(i_m11);
        e12 = AW'(i_m12);
        e20 = AW'(i_m20);
        e21 = AW'(i_m21);
        e22 = AW'(i_m22);
        w_trace = e00 + e11 + e22;

        priority if (w_trace > 0) begin
            w_branch = rmq_pkg::BR_W;
        end else if (e00 > e11 && e00 > e22) begin
            w_branch = rmq_pkg::BR_X;
        end else if (e11 > e22) begin
            w_branch = rmq_pkg::BR_Y;
        end else begin
            w_branch = rmq_pkg::BR_Z;
        end

        unique case (w_branch)
            rmq_pkg::BR_W: begin
                w_a = w_trace + ONE;
                w_p[rmq_pkg::LANE_W] = w_a;
                w_p[rmq_pkg::LANE_X] = e21 - e12;
                w_p[rmq_pkg::LANE_Y] = e02 - e20;
                w_p[rmq_pkg::LANE_Z] = e10 - e01;
            end
            rmq_pkg::BR_X: begin
                w_a = ONE + e00 - e11 - e22;
                w_p[rmq_pkg::LANE_W] = e21 - e12;
                w_p[rmq_pkg::LANE_X] = w_a;
                w_p[rmq_pkg::LANE_Y] = e01 + e10;
                w_p[rmq_pkg::LANE_Z] = e02 + e20;
            end
            rmq_pkg::BR_Y: begin
                w_a = ONE + e11 - e00 - e22;
                w_p[rmq_pkg::LANE_W] = e02 - e20;
                w_p[rmq_pkg::LANE_X] = e01 + e10;
                w_p[rmq_pkg::LANE_Y] = w_a;
                w_p[rmq_pkg::LANE_Z] = e12 + e21;
            end
            default: begin
                w_a = ONE + e22 - e00 - e11;
                w_p[rmq_pkg::LANE_W] = e10 - e01;
                w_p[rmq_pkg::LANE_X] = e02 + e20;
                w_p[rmq_pkg::LANE_Y] = e12 + e21;
                w_p[rmq_pkg::LANE_Z] = w_a;
            end
        endcase

        // a radicand at or below zero has no root: forced to identity later
        w_bad  = w_a[AW-1] || (w_a == '0);
        n_data = {w_bad, w_a, w_p[rmq_pkg::LANE_W], w_p[rmq_pkg::LANE_Z],
                  w_p[rmq_pkg::LANE_Y], w_p[rmq_pkg::LANE_X]};
    end

    assign w_advance = !r_valid || i_ready;
    assign o_full    = !w_advance;
    assign o_valid   = r_valid;
    assign o_data    = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_advance) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && i_push) begin
            r_data <= n_data;
        end
    end

endmodule

[hw/rtl/rmq_back.sv]
// back end: sum of squares, tolerance test, pipelined root and per-lane dividers
module rmq_back #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [rmq_pkg::calc_iw(FRAC_BITS)-1:0] i_data,
    output logic                                   o_pop,
    input  logic [rmq_pkg::TOL_SQ_W-1:0]           i_tol_sq,
    output logic                                   o_push,
    output logic [rmq_pkg::OUT_W-1:0]              o_data,
    input  logic                                   i_full
);

    localparam int AW  = rmq_pkg::calc_aw(FRAC_BITS);
    localparam int SW  = 2 * AW;
    localparam int CW  = 2 * AW + 2;
    localparam int PRW = AW - 1 + rmq_pkg::TOL_SQ_W;
    localparam int RW  = AW;
    localparam int NW  = AW + FRAC_BITS;
    localparam int QW  = FRAC_BITS + 1;
    localparam int VW  = (QW + 1 > rmq_pkg::DATA_W + 1) ? QW + 1 : rmq_pkg::DATA_W + 1;
    localparam int L   = rmq_pkg::LANES;
    localparam int DW  = rmq_pkg::DATA_W;
    localparam int ONE_INT = 1 << FRAC_BITS;
    localparam logic signed [VW-1:0] VMAX = VW'(rmq_pkg::SAT_MAX);
    localparam logic signed [VW-1:0] VMIN = VW'(rmq_pkg::SAT_MIN);
    localparam logic [DW-1:0] W_IDENT =
        (ONE_INT > rmq_pkg::SAT_MAX) ? DW'(rmq_pkg::SAT_MAX) : DW'(ONE_INT);

    logic w_en;

    // stage 1: squares and tolerance product
    logic                 r_s1_v;
    logic [SW-1:0]        r_s1_sq [L];
    logic signed [AW-1:0] r_s1_p  [L];
    logic [PRW-1:0]       r_s1_prod;
    logic                 r_s1_bad;

    // root stages, index 0 is loaded by the sum stage
    logic                 r_sq_v     [RW+1];
    logic [SW-1:0]        r_sq_rem   [RW+1];
    logic [AW-1:0]        r_sq_root  [RW+1];
    logic signed [AW-1:0] r_sq_p     [RW+1][L];
    logic                 r_sq_degen [RW+1];

    // divider stages, index 0 is loaded by the numerator stage
    logic                 r_dv_v     [QW+1];
    logic [NW-1:0]        r_dv_num   [QW+1][L];
    logic [QW-1:0]        r_dv_q     [QW+1][L];
    logic                 r_dv_neg   [QW+1][L];
    logic [AW-1:0]        r_dv_len   [QW+1];
    logic                 r_dv_degen [QW+1];

    logic                 r_o_v;
    logic [rmq_pkg::OUT_W-1:0] r_o_data;

    assign w_en   = !(r_o_v && i_full);
    assign o_pop  = w_en && i_valid;
    assign o_push = r_o_v && !i_full;
    assign o_data = r_o_data;

    // stage 1
    logic signed [AW-1:0] w_in_p [L];
    logic signed [AW-1:0] w_in_a;
    logic signed [SW-1:0] w_in_sq [L];
    logic [PRW-1:0]       w_in_prod;

    always_comb begin
        for (int l = 0; l < L; l++) begin
            w_in_p[l]  = $signed(i_data[AW*l +: AW]);
            w_in_sq[l] = w_in_p[l] * w_in_p[l];
        end
        w_in_a    = $signed(i_data[AW*L +: AW]);
        w_in_prod = i_tol_sq * w_in_a[AW-2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < L; l++) begin
                r_s1_sq[l] <= $unsigned(w_in_sq[l]);
                r_s1_p[l]  <= w_in_p[l];
            end
            r_s1_prod <= w_in_prod;
            r_s1_bad  <= i_data[AW*(L+1)];
        end
    end

    // stage 2: sum and degenerate test
    logic [SW-1:0] w_sum;
    logic [CW-1:0] w_lim;

    always_comb begin
        w_sum = r_s1_sq[0] + r_s1_sq[1] + r_s1_sq[2] + r_s1_sq[3];
        w_lim = (CW'(r_s1_prod) << 2) >> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_v[0] <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_rem[0]   <= w_sum;
            r_sq_root[0]  <= '0;
            r_sq_degen[0] <= r_s1_bad || (CW'(w_sum) <= w_lim);
            for (int l = 0; l < L; l++) begin
                r_sq_p[0][l] <= r_s1_p[l];
            end
        end
    end

    // one root bit per stage, most significant first
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int BI = RW - 1 - k;
        logic [SW-1:0] w_trial;

        assign w_trial = (SW'(r_sq_root[k]) << (BI + 1)) + (SW'(1) << (2 * BI));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (r_sq_rem[k] >= w_trial) begin
                    r_sq_rem[k+1]  <= r_sq_rem[k] - w_trial;
                    r_sq_root[k+1] <= r_sq_root[k] | (AW'(1) << BI);
                end else begin
                    r_sq_rem[k+1]  <= r_sq_rem[k];
                    r_sq_root[k+1] <= r_sq_root[k];
                end
                r_sq_degen[k+1] <= r_sq_degen[k];
                for (int l = 0; l < L; l++) begin
                    r_sq_p[k+1][l] <= r_sq_p[k][l];
                end
            end
        end
    end

    // numerator stage: magnitude scaled up, half the length added for rounding
    logic [AW-1:0] w_mag [L];

    always_comb begin
        for (int l = 0; l < L; l++) begin
            w_mag[l] = r_sq_p[RW][l][AW-1] ? AW'(-r_sq_p[RW][l]) : AW'(r_sq_p[RW][l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_v[0] <= r_sq_v[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < L; l++) begin
                r_dv_num[0][l] <= (NW'(w_mag[l]) << FRAC_BITS) + NW'(r_sq_root[RW] >> 1);
                r_dv_q[0][l]   <= '0;
                r_dv_neg[0][l] <= r_sq_p[RW][l][AW-1];
            end
            r_dv_len[0]   <= r_sq_root[RW];
            r_dv_degen[0] <= r_sq_degen[RW];
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int BI = FRAC_BITS - j;
        logic [NW-1:0] w_den;

        assign w_den = NW'(r_dv_len[j]) << BI;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_v[j+1] <= r_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int l = 0; l < L; l++) begin
                    if (r_dv_num[j][l] >= w_den) begin
                        r_dv_num[j+1][l] <= r_dv_num[j][l] - w_den;
                        r_dv_q[j+1][l]   <= r_dv_q[j][l] | (QW'(1) << BI);
                    end else begin
                        r_dv_num[j+1][l] <= r_dv_num[j][l];
                        r_dv_q[j+1][l]   <= r_dv_q[j][l];
                    end
                    r_dv_neg[j+1][l] <= r_dv_neg[j][l];
                end
                r_dv_len[j+1]   <= r_dv_len[j];
                r_dv_degen[j+1] <= r_dv_degen[j];
            end
        end
    end

    // sign, saturation and identity select
    logic signed [VW-1:0] w_val [L];
    logic [DW-1:0]        w_res [L];

    always_comb begin
        for (int l = 0; l < L; l++) begin
            w_val[l] = r_dv_neg[QW][l] ? -$signed(VW'(r_dv_q[QW][l]))
                                       : $signed(VW'(r_dv_q[QW][l]));
            if (w_val[l] > VMAX) begin
                w_res[l] = DW'(rmq_pkg::SAT_MAX);
            end else if (w_val[l] < VMIN) begin
                w_res[l] = DW'(rmq_pkg::SAT_MIN);
            end else begin
                w_res[l] = w_val[l][DW-1:0];
            end
            if (r_dv_degen[QW]) begin
                w_res[l] = (l == rmq_pkg::LANE_W) ? W_IDENT : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_o_v <= r_dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_data <= {r_dv_degen[QW], w_res[rmq_pkg::LANE_W], w_res[rmq_pkg::LANE_Z],
                         w_res[rmq_pkg::LANE_Y], w_res[rmq_pkg::LANE_X]};
        end
    end

endmodule

[tb/rotation_matrix_to_quaternion_unit_test.sv]
// testbench for the rotation matrix to quaternion unit: queued stimulus, predictor and checker
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_unit_test;

    localparam int DW = rmq_pkg::DATA_W;
    localparam int TW = rmq_pkg::TOL_W;
    localparam int FRAC = 14;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam int LATENCY = 40;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [DW-1:0] m [9];
    } t_matrix;

    typedef struct {
        logic signed [DW-1:0] qx, qy, qz, qw;
        logic                 degen;
    } t_quat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic signed [DW-1:0] mat_drv [9];
    logic signed [DW-1:0] o_quat_x, o_quat_y, o_quat_z, o_quat_w;
    logic o_was_degenerate;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [TW-1:0] i_cfg_zero_tolerance = '0;

    t_matrix pending_matrices[$];
    t_quat   expected_quats[$];
    logic [TW-1:0] tol_model = TW'(rmq_pkg::TOL_RESET);
    int  errors = 0;
    int  checked = 0;
    int  degen_seen = 0;
    longint cycles = 0;
    bit  hold_off = 1'b0;
    bit  sender_pause = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  branch_count [4] = '{0, 0, 0, 0};
    logic [TW-1:0] tol_value_list [6] = '{10'd0, 10'd1023, 10'd5, 10'd300, 10'd1000, 10'd64};

    initial begin
        for (int k = 0; k < 9; k++) mat_drv[k] = '0;
    end

    always #5 i_clk = ~i_clk;

    rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FRAC)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_m00(mat_drv[0]), .i_m01(mat_drv[1]), .i_m02(mat_drv[2]),
        .i_m10(mat_drv[3]), .i_m11(mat_drv[4]), .i_m12(mat_drv[5]),
        .i_m20(mat_drv[6]), .i_m21(mat_drv[7]), .i_m22(mat_drv[8]),
        .empty(empty), .pop(pop),
        .o_quat_x(o_quat_x), .o_quat_y(o_quat_y), .o_quat_z(o_quat_z),
        .o_quat_w(o_quat_w), .o_was_degenerate(o_was_degenerate),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_zero_tolerance(i_cfg_zero_tolerance)
    );

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [DW-1:0] clamp16(longint v);
        if (v > rmq_pkg::SAT_MAX) v = rmq_pkg::SAT_MAX;
        if (v < rmq_pkg::SAT_MIN) v = rmq_pkg::SAT_MIN;
        return v[DW-1:0];
    endfunction

    // round half away from zero
    function automatic longint scale_component(longint c, longint unsigned len);
        longint unsigned mag, q;
        mag = (c < 0) ? -c : c;
        q = ((mag << FRAC) + (len >> 1)) / len;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_quat shepperd_quat(t_matrix mt, logic [TW-1:0] tol);
        longint e [9];
        longint tr, a, px, py, pz, pw;
        longint unsigned sum, lim, len;
        t_quat q;
        rmq_pkg::t_branch br;
        bit dg;
        for (int k = 0; k < 9; k++) e[k] = mt.m[k];
        tr = e[0] + e[4] + e[8];
        if (tr > 0) begin
            br = rmq_pkg::BR_W;
            a = tr + ONE; pw = a;
            px = e[7] - e[5]; py = e[2] - e[6]; pz = e[3] - e[1];
        end else if (e[0] > e[4] && e[0] > e[8]) begin
            br = rmq_pkg::BR_X;
            a = ONE + e[0] - e[4] - e[8]; px = a;
            pw = e[7] - e[5]; py = e[1] + e[3]; pz = e[2] + e[6];
        end else if (e[4] > e[8]) begin
            br = rmq_pkg::BR_Y;
            a = ONE + e[4] - e[0] - e[8]; py = a;
            pw = e[2] - e[6]; px = e[1] + e[3]; pz = e[5] + e[7];
        end else begin
            br = rmq_pkg::BR_Z;
            a = ONE + e[8] - e[0] - e[4]; pz = a;
            pw = e[3] - e[1]; px = e[2] + e[6]; py = e[5] + e[7];
        end
        branch_count[br]++;
        dg = 1'b0;
        len = 0;
        if (a <= 0) begin
            dg = 1'b1;
        end else begin
            sum = px * px + py * py + pz * pz + pw * pw;
            lim = (64'd4 * tol * tol * longint'(a)) >> FRAC;
            if (sum <= lim) dg = 1'b1;
            else begin
                len = int_sqrt(sum);
                if (len == 0) dg = 1'b1;
            end
        end
        if (dg) begin
            q.qx = '0; q.qy = '0; q.qz = '0; q.qw = clamp16(ONE); q.degen = 1'b1;
        end else begin
            q.qx = clamp16(scale_component(px, len));
            q.qy = clamp16(scale_component(py, len));
            q.qz = clamp16(scale_component(pz, len));
            q.qw = clamp16(scale_component(pw, len));
            q.degen = 1'b0;
        end
        return q;
    endfunction

    // sender: one transaction per push with a random gap between items
    always @(posedge i_clk) begin
        int gap;
        if (i_rst_n) begin
            if (push && !full) begin
                expected_quats.push_back(shepperd_quat(pending_matrices.pop_front(), tol_model));
                gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
                if (gap == 0 && !sender_pause && pending_matrices.size() > 0) begin
                    push <= 1'b1;
                    for (int k = 0; k < 9; k++) mat_drv[k] <= pending_matrices[0].m[k];
                end else begin
                    push <= 1'b0;
                end
                send_gap <= gap;
            end else if (!push) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (!sender_pause && pending_matrices.size() > 0) begin
                    push <= 1'b1;
                    for (int k = 0; k < 9; k++) mat_drv[k] <= pending_matrices[0].m[k];
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_quat want;
        int gap;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_quats.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d", $time,
                             o_quat_x, o_quat_y, o_quat_z, o_quat_w);
                    errors++;
                end else begin
                    want = expected_quats.pop_front();
                    checked++;
                    if (want.degen) degen_seen++;
                    if (o_quat_x !== want.qx || o_quat_y !== want.qy || o_quat_z !== want.qz ||
                        o_quat_w !== want.qw || o_was_degenerate !== want.degen) begin
                        $display("%0t: mismatch expected %0d %0d %0d %0d d%0b actual %0d %0d %0d %0d d%0b",
                                 $time, want.qx, want.qy, want.qz, want.qw, want.degen,
                                 o_quat_x, o_quat_y, o_quat_z, o_quat_w, o_was_degenerate);
                        errors++;
                    end
                end
                gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
                recv_gap <= gap;
                pop <= (gap == 0) && !hold_off;
            end else if (hold_off) begin
                pop <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic add_matrix(input longint v [9]);
        t_matrix mt;
        for (int k = 0; k < 9; k++) mt.m[k] = DW'(v[k]);
        pending_matrices.push_back(mt);
    endtask

    function automatic logic signed [DW-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return $signed(DW'($urandom_range(0, 65535)));
            default: return $signed(DW'($urandom_range(0, 32768) - 16384));
        endcase
    endfunction

    // mostly near-rotation: a permuted signed-axis matrix plus small noise; one in four is random words
    task automatic add_random_matrices(input int count);
        t_matrix mt;
        int perm [3];
        int sg, tmp, j;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                for (int k = 0; k < 9; k++) mt.m[k] = rand_word();
            end else begin
                perm = '{0, 1, 2};
                for (int k = 2; k > 0; k--) begin
                    j = $urandom_range(0, k);
                    tmp = perm[k]; perm[k] = perm[j]; perm[j] = tmp;
                end
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++) begin
                        sg = $urandom_range(0, 1) ? 1 : -1;
                        mt.m[r*3+c] = DW'((perm[r] == c ? sg * 16384 : 0) +
                                          int'($urandom_range(0, 4000)) - 2000);
                    end
            end
            pending_matrices.push_back(mt);
        end
    endtask

    task automatic wait_drained();
        while (pending_matrices.size() > 0 || push || expected_quats.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TW-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_zero_tolerance <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tol_model = v;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, every branch, extremes, zero and non-rotation radicands
        add_matrix('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384});
        add_matrix('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
        add_matrix('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384});
        add_matrix('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384});
        add_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        add_matrix('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768});
        add_matrix('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
        add_matrix('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768});
        add_matrix('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768});
        add_matrix('{0, -16384, 0, 16384, 0, 0, 0, 0, 16384});
        add_matrix('{-8192, 0, 0, 0, -8192, 0, 0, 0, -8192});
        add_matrix('{-16384, 0, 0, 0, -16384, 0, 0, 0, -16383});
        add_matrix('{0, 1, 0, 1, 0, 0, 0, 0, -16384});
        wait_drained();

        foreach (tol_value_list[i]) begin
            write_tolerance(tol_value_list[i]);
            add_random_matrices(i == 0 ? 200 : 180);
            if (i == 1) begin
                // receiver stalls while sender keeps offering, so the block fills up
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            if (i == 2) begin
                while (pending_matrices.size() > 90) @(posedge i_clk);
                sender_pause = 1'b1;
                while (push || expected_quats.size() > 0) @(posedge i_clk);
                sender_pause = 1'b0;
            end
            wait_drained();
        end
        write_tolerance(TW'(rmq_pkg::TOL_RESET));
        add_random_matrices(150);
        wait_drained();

        $display("checked %0d quaternions (%0d degenerate), branches w/x/y/z %0d/%0d/%0d/%0d",
                 checked, degen_seen, branch_count[rmq_pkg::BR_W], branch_count[rmq_pkg::BR_X],
                 branch_count[rmq_pkg::BR_Y], branch_count[rmq_pkg::BR_Z]);
        $display("tolerance settings from 0 to 1023 with random back-pressure on both sides");
        if (errors == 0) begin
            $display("rotation_matrix_to_quaternion_unit verification clean");
        end else begin
            $display("rotation_matrix_to_quaternion_unit verification failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("rotation_matrix_to_quaternion_unit verification failed");
            $finish;
        end
    end

endmodule
